/* rtl/sbot_pkg.sv */
// ----------------------------------------------------------------------------
// sbot_pkg: shared types and constants for the segment/box overlap test
// Coordinate width, widened difference widths and the per-axis lane result.
// ----------------------------------------------------------------------------
package sbot_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;

	// per-axis lane result
	typedef struct packed {
		logic  in_s;
		logic  in_e;
		logic  zero_dir;
		logic  zero_pass;
		diff_t nmin;
		diff_t nmax;
		diff_t den;
	} lane_t;
endpackage

/* rtl/sbot_lane.sv */
// ----------------------------------------------------------------------------
// sbot_lane: one axis of the test
// Orders the box corners, tests both endpoints and forms entry/exit fractions.
// ----------------------------------------------------------------------------
module sbot_lane import sbot_pkg::*; (
	input  coord_t s,
	input  coord_t e,
	input  coord_t a,
	input  coord_t b,
	output lane_t  res
);
	coord_t lo, hi;
	diff_t  sw, ew, low, hiw, d;

	always_comb begin
		// order corners
		lo  = (a < b) ? a : b;
		hi  = (a < b) ? b : a;
		sw  = diff_t'(s);
		ew  = diff_t'(e);
		low = diff_t'(lo);
		hiw = diff_t'(hi);
		d   = ew - sw;
		res.in_s      = (s >= lo) && (s <= hi);
		res.in_e      = (e >= lo) && (e <= hi);
		res.zero_dir  = (d == '0);
		res.zero_pass = (lo < s) && (s < hi);
		// form fractions with non-negative denominator (zero only on zero direction)
		if (d > 0) begin
			res.den  = d;
			res.nmin = low - sw;
			res.nmax = hiw - sw;
		end else begin
			res.den  = -d;
			res.nmin = sw - hiw;
			res.nmax = sw - low;
		end
	end
endmodule

/* rtl/sbot_merge.sv */
// ----------------------------------------------------------------------------
// sbot_merge: combine the three lanes
// Stage 1 forms cross products, stage 2 compares and folds the lanes.
// ----------------------------------------------------------------------------
module sbot_merge import sbot_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_s0,
	input  lane_t lane_s0 [3],
	output logic  vld_s2,
	output logic  hit_s2,
	output logic  inside_s2
);
	// lane order for pairwise cross products: (0,1), (0,2), (1,2)
	lane_t lane_s1 [3];
	prod_t xmin_ab_s1 [3], xmin_ba_s1 [3], xmax_ab_s1 [3], xmax_ba_s1 [3];
	logic  vld_s1;
	prod_t pmin_ab [3], pmin_ba [3], pmax_ab [3], pmax_ba [3];
	logic  [1:0] ia [3], ib [3];

	always_comb begin
		ia[0] = 2'd0; ib[0] = 2'd1;
		ia[1] = 2'd0; ib[1] = 2'd2;
		ia[2] = 2'd1; ib[2] = 2'd2;
		for (int p = 0; p < 3; p++) begin
			pmin_ab[p] = prod_t'(lane_s0[ia[p]].nmin) * prod_t'(lane_s0[ib[p]].den);
			pmin_ba[p] = prod_t'(lane_s0[ib[p]].nmin) * prod_t'(lane_s0[ia[p]].den);
			pmax_ab[p] = prod_t'(lane_s0[ia[p]].nmax) * prod_t'(lane_s0[ib[p]].den);
			pmax_ba[p] = prod_t'(lane_s0[ib[p]].nmax) * prod_t'(lane_s0[ia[p]].den);
		end
	end

	// register products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_s0;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1    <= lane_s0;
		xmin_ab_s1 <= pmin_ab;
		xmin_ba_s1 <= pmin_ba;
		xmax_ab_s1 <= pmax_ab;
		xmax_ba_s1 <= pmax_ba;
	end

	// fold: entry max does not exceed exit min iff every entry <= every exit
	logic  ep_in, pass, act_i, act_j;
	always_comb begin
		ep_in = (lane_s1[0].in_s && lane_s1[1].in_s && lane_s1[2].in_s) ||
			(lane_s1[0].in_e && lane_s1[1].in_e && lane_s1[2].in_e);
		pass = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (lane_s1[k].zero_dir) begin
				if (!lane_s1[k].zero_pass) pass = 1'b0;
			end else begin
				// own entry vs own exit, below 1, above 0
				if (lane_s1[k].nmax < lane_s1[k].nmin) pass = 1'b0;
				if (!(lane_s1[k].nmin < lane_s1[k].den)) pass = 1'b0;
				if (!(lane_s1[k].nmax > 0)) pass = 1'b0;
			end
		end
		for (int p = 0; p < 3; p++) begin
			act_i = !lane_s1[ia[p]].zero_dir;
			act_j = !lane_s1[ib[p]].zero_dir;
			if (act_i && act_j) begin
				// exit_b < entry_a  or exit_a < entry_b
				if (xmax_ba_s1[p] < xmin_ab_s1[p]) pass = 1'b0;
				if (xmax_ab_s1[p] < xmin_ba_s1[p]) pass = 1'b0;
			end
		end
	end

	// register the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2    <= ep_in || pass;
		inside_s2 <= ep_in;
	end
endmodule

/* rtl/segment_box_overlap_test.sv */
// ----------------------------------------------------------------------------
// segment_box_overlap_test: exact 3D segment versus axis-aligned box test
// Three axis lanes feed a merging stage that folds entry and exit fractions.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve coordinate ports and raise start; a word is taken at
//   each rising edge with start high. busy is always low, so a new word
//   may be offered every cycle (one word per cycle sustained).
//   The result word appears on hit and endpoint_inside after
//   acceptance, marked by done for exactly one cycle. The receiver cannot
//   stall; results arrive in acceptance order.
//   Latency is set by the cross-product register and the result register.
//   Reset clears the pipeline valid bits; no result is issued until a new
//   word is accepted.
//   Corners may come in either order per axis. A zero-length segment
//   outside the box reports a miss.
// ----------------------------------------------------------------------------
module segment_box_overlap_test import sbot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	output logic   done,
	input  coord_t start_x,
	input  coord_t start_y,
	input  coord_t start_z,
	input  coord_t end_x,
	input  coord_t end_y,
	input  coord_t end_z,
	input  coord_t box_lo_x,
	input  coord_t box_lo_y,
	input  coord_t box_lo_z,
	input  coord_t box_hi_x,
	input  coord_t box_hi_y,
	input  coord_t box_hi_z,
	output logic   hit,
	output logic   endpoint_inside
);
	lane_t lane [3];

	assign busy = 1'b0;

	sbot_lane u_lane_x (.s(start_x), .e(end_x), .a(box_lo_x), .b(box_hi_x), .res(lane[0]));
	sbot_lane u_lane_y (.s(start_y), .e(end_y), .a(box_lo_y), .b(box_hi_y), .res(lane[1]));
	sbot_lane u_lane_z (.s(start_z), .e(end_z), .a(box_lo_z), .b(box_hi_z), .res(lane[2]));

	sbot_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s0    (start && !busy),
		.lane_s0   (lane),
		.vld_s2    (done),
		.hit_s2    (hit),
		.inside_s2 (endpoint_inside)
	);
endmodule

/* rtl/sbot_checker.sv */
// ----------------------------------------------------------------------------
// sbot_checker: port-level checks for the overlap test
// Watches latency and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module sbot_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hit,
	input logic endpoint_inside
);
	// an inside endpoint is always a hit
	a_inside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && endpoint_inside |-> hit) else $error("inside without hit");

	// each accepted word is followed by a result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("result missing");

	// no result without an accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2)) else $error("spurious result");
endmodule

bind segment_box_overlap_test sbot_checker u_sbot_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.hit(hit), .endpoint_inside(endpoint_inside)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for segment_box_overlap_test
// Directed table of segment/box words (corners, extremes, zero-direction and
// zero-length cases) followed by random words biased toward small boxes and
// near misses. Every result is checked against an exact rational predictor.
// ----------------------------------------------------------------------------
module tb;
	import sbot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM       = 880;
	localparam int LATENCY        = 2;

	typedef struct {
		coord_t c[12];
		logic   known;     // expected result typed in
		logic   exp_hit;
		logic   exp_inside;
	} query_t;

	typedef struct {
		logic hit;
		logic ep_in;
	} verdict_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	logic   done;
	coord_t crd[12];
	logic   hit;
	logic   endpoint_inside;

	verdict_t expected_q[$];
	int       n_errors;
	int       idle_cycles;
	logic     quiet;

	segment_box_overlap_test u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.done            (done),
		.start_x         (crd[0]),
		.start_y         (crd[1]),
		.start_z         (crd[2]),
		.end_x           (crd[3]),
		.end_y           (crd[4]),
		.end_z           (crd[5]),
		.box_lo_x        (crd[6]),
		.box_lo_y        (crd[7]),
		.box_lo_z        (crd[8]),
		.box_hi_x        (crd[9]),
		.box_hi_y        (crd[10]),
		.box_hi_z        (crd[11]),
		.hit             (hit),
		.endpoint_inside (endpoint_inside)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// true when an/ad < bn/bd, denominators positive
	function automatic logic frac_lt(longint an, longint ad, longint bn, longint bd);
		logic signed [127:0] l, r;
		l = 128'(an) * 128'(bd);
		r = 128'(bn) * 128'(ad);
		return l < r;
	endfunction

	// compute hit and endpoint-inside for one segment/box word
	function automatic verdict_t overlap_verdict(query_t q);
		verdict_t v;
		longint s[3], e[3], lo[3], hi[3];
		longint d, nmin, nmax, den, en_n, en_d, ex_n, ex_d;
		logic   in_s, in_e, pass, have;
		in_s = 1'b1; in_e = 1'b1; pass = 1'b1; have = 1'b0;
		en_n = 0; en_d = 1; ex_n = 0; ex_d = 1;
		for (int k = 0; k < 3; k++) begin
			s[k]  = longint'(q.c[k]);
			e[k]  = longint'(q.c[3+k]);
			lo[k] = (q.c[6+k] < q.c[9+k]) ? longint'(q.c[6+k]) : longint'(q.c[9+k]);
			hi[k] = (q.c[6+k] < q.c[9+k]) ? longint'(q.c[9+k]) : longint'(q.c[6+k]);
			if (s[k] < lo[k] || s[k] > hi[k]) in_s = 1'b0;
			if (e[k] < lo[k] || e[k] > hi[k]) in_e = 1'b0;
		end
		if (in_s || in_e) begin
			v.hit = 1'b1;
			v.ep_in = 1'b1;
			return v;
		end
		for (int k = 0; k < 3; k++) begin
			d = e[k] - s[k];
			if (d == 0) begin
				if (!(lo[k] < s[k] && s[k] < hi[k])) pass = 1'b0;
				continue;
			end
			if (d > 0) begin
				den = d; nmin = lo[k] - s[k]; nmax = hi[k] - s[k];
			end else begin
				den = -d; nmin = s[k] - hi[k]; nmax = s[k] - lo[k];
			end
			if (!have) begin
				en_n = nmin; en_d = den; ex_n = nmax; ex_d = den;
				have = 1'b1;
			end else begin
				if (frac_lt(en_n, en_d, nmin, den)) begin
					en_n = nmin; en_d = den;
				end
				if (frac_lt(nmax, den, ex_n, ex_d)) begin
					ex_n = nmax; ex_d = den;
				end
			end
		end
		if (pass && have) begin
			if (frac_lt(ex_n, ex_d, en_n, en_d)) pass = 1'b0;
			if (!(en_n < en_d)) pass = 1'b0;
			if (!(ex_n > 0)) pass = 1'b0;
		end
		v.hit = pass;
		v.ep_in = 1'b0;
		return v;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		n_errors++;
	endtask

	function automatic query_t make_query(coord_t sx, coord_t sy, coord_t sz,
		coord_t ex, coord_t ey, coord_t ez, coord_t ax, coord_t ay, coord_t az,
		coord_t bx, coord_t by, coord_t bz, logic known, logic h, logic ins);
		query_t q;
		q.c = '{sx, sy, sz, ex, ey, ez, ax, ay, az, bx, by, bz};
		q.known = known;
		q.exp_hit = h;
		q.exp_inside = ins;
		return q;
	endfunction

	// random coordinate: mostly small, sometimes full range
	function automatic coord_t rand_coord(int span);
		if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
		return coord_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic query_t random_query();
		query_t q;
		int     span;
		int     ax;
		span = ($urandom_range(0, 3) == 0) ? 1000 : 12;
		for (int i = 0; i < 12; i++) q.c[i] = rand_coord(span);
		// sometimes flatten an axis or collapse the segment
		ax = $urandom_range(0, 2);
		if ($urandom_range(0, 5) == 0) q.c[3 + ax] = q.c[ax];
		if ($urandom_range(0, 19) == 0) begin
			q.c[3] = q.c[0]; q.c[4] = q.c[1]; q.c[5] = q.c[2];
		end
		q.known = 1'b0;
		q.exp_hit = 1'b0;
		q.exp_inside = 1'b0;
		return q;
	endfunction

	// offer one word, idling at random, and log its expected verdict
	task automatic send_word(query_t q);
		verdict_t v;
		while (!quiet && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			@(posedge clk);
		end
		v = overlap_verdict(q);
		if (q.known && (v.hit !== q.exp_hit || v.ep_in !== q.exp_inside))
			report_mismatch("directed row disagrees with predictor");
		if (q.known) begin
			v.hit = q.exp_hit;
			v.ep_in = q.exp_inside;
		end
		start <= 1'b1;
		for (int i = 0; i < 12; i++) crd[i] <= q.c[i];
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(v);
	endtask

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with no word outstanding");
			end else begin
				v = expected_q.pop_front();
				if (hit !== v.hit)
					report_mismatch($sformatf("hit %b, want %b", hit, v.hit));
				if (endpoint_inside !== v.ep_in)
					report_mismatch($sformatf("endpoint_inside %b, want %b",
						endpoint_inside, v.ep_in));
			end
		end
	end

	// watchdog: count cycles with nothing accepted and no result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		query_t table_q[$];
		coord_t mx, mn;
		mx = coord_t'(32'h7fffffff);
		mn = coord_t'(32'h80000000);
		n_errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		start = 1'b0;
		for (int i = 0; i < 12; i++) crd[i] = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start inside
		table_q.push_back(make_query(0,0,0, 50,50,50, -1,-1,-1, 1,1,1, 1, 1, 1));
		// end on a face, corners swapped
		table_q.push_back(make_query(-9,0,0, 5,0,0, 5,2,2, -5,-2,-2, 1, 1, 1));
		// straight through, both outside
		table_q.push_back(make_query(-10,0,0, 10,0,0, -1,-1,-1, 1,1,1, 0, 0, 0));
		// clear miss
		table_q.push_back(make_query(-10,5,0, 10,5,0, -1,-1,-1, 1,1,1, 1, 0, 0));
		// zero direction on y exactly on a face: miss
		table_q.push_back(make_query(-10,1,0, 10,1,0, -1,-1,-1, 1,1,1, 1, 0, 0));
		// zero-length segment outside
		table_q.push_back(make_query(7,7,7, 7,7,7, -1,-1,-1, 1,1,1, 1, 0, 0));
		// stops short of the box
		table_q.push_back(make_query(-10,0,0, -3,0,0, -1,-1,-1, 1,1,1, 1, 0, 0));
		// diagonals passing just outside an edge
		table_q.push_back(make_query(-3,0,0, 0,3,0, -1,-1,-1, 1,1,1, 0, 0, 0));
		table_q.push_back(make_query(-4,0,0, 0,4,0, -1,-1,-1, 1,1,1, 0, 0, 0));
		// negative direction
		table_q.push_back(make_query(10,10,10, -10,-10,-10, -1,-1,-1, 1,1,1, 0, 0, 0));
		// extreme coordinates
		table_q.push_back(make_query(mn,mn,mn, mx,mx,mx, -1,-1,-1, 1,1,1, 0, 0, 0));
		table_q.push_back(make_query(mx,mx,mx, mn,mn,mn, mn,mn,mn, mx,mx,mx, 1, 1, 1));
		table_q.push_back(make_query(mn,0,0, mx,0,0, mx,-1,-1, mx,1,1, 0, 0, 0));
		table_q.push_back(make_query(mx,mn,mx, mn,mx,mn, mn,mn,mn, mn,mn,mn, 0, 0, 0));
		table_q.push_back(make_query(mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx, 1, 1, 1));
		table_q.push_back(make_query(-1,-1,-1, -1,-1,-1, 0,0,0, 0,0,0, 1, 0, 0));
		// degenerate box, segment through it
		table_q.push_back(make_query(-5,0,0, 5,0,0, 0,0,0, 0,0,0, 0, 0, 0));
		table_q.push_back(make_query(-5,-5,-5, 5,5,5, 0,0,0, 0,0,0, 0, 0, 0));

		foreach (table_q[i]) send_word(table_q[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 300 && i < 450);
			send_word(random_query());
		end
		start <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
